FILE: rtl/ising_pkg.sv
// shared widths, reset values and codes for the ising lattice engine
package ising_pkg;

   // transaction field widths
   localparam int SITE_W      = 12;
   localparam int RAND_W      = 16;
   localparam int THRESH_W    = 17;
   localparam int MAG_W       = 14;
   localparam int ENERGY_W    = 15;
   localparam int CSR_INDEX_W = 1;

   // lattice side default
   localparam int SIDE_DEFAULT = 64;

   // saturation bounds of the measure sums
   localparam int MAG_MIN    = -(1 << (MAG_W - 1));
   localparam int MAG_MAX    = (1 << (MAG_W - 1)) - 1;
   localparam int ENERGY_MIN = -(1 << (ENERGY_W - 1));
   localparam int ENERGY_MAX = (1 << (ENERGY_W - 1)) - 1;

   // acceptance thresholds after reset
   localparam logic [THRESH_W-1:0] ACCEPT_FOUR_RESET  = 17'd8869;
   localparam logic [THRESH_W-1:0] ACCEPT_EIGHT_RESET = 17'd1200;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPT_FOUR  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPT_EIGHT = 1'b1;

   // request kinds
   localparam logic KIND_MEASURE = 1'b1;

endpackage

FILE: rtl/ising_metropolis_lattice.sv
// metropolis single-spin-flip engine for a wrapped square ising lattice
//
// The lattice holds SIDE x SIDE one-bit spins in a block ram (1 = +1, 0 = -1).
// After reset the block sweeps the ram once, one site per cycle, to set every
// spin to +1; busy stays high during the sweep. A transaction is taken when
// start is high and busy is low. A flip attempt (kind 0) works in steps from
// the accepting edge to its result strobe: the states MUL, REM and COL find
// the site's column with a reciprocal multiply and one correction, five ram
// reads in READ fetch the site and its four wrapped neighbours, and DECIDE
// decides and writes the spin back if it flips. A site beyond the lattice is
// answered in the very next cycle without touching the ram. A measure (kind 1)
// streams the lattice through the ram read port, one site a cycle, and then
// row 0 once more for the wrapped vertical bonds. Each result is shown for
// one cycle under rsp_valid and cannot be held off by the receiver; the next
// start is taken in the cycle of the strobe. Thresholds are written through
// the csr port; the user must write them only while the block is idle, as the
// block itself does not enforce it.
module ising_metropolis_lattice #(
   parameter int SIDE = ising_pkg::SIDE_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_kind,
   input  logic [ising_pkg::SITE_W-1:0]            req_site,
   input  logic [ising_pkg::RAND_W-1:0]            req_rand_value,
   output logic                                    rsp_valid,
   output logic                                    rsp_flipped,
   output logic                                    rsp_spin_after,
   output logic signed [ising_pkg::MAG_W-1:0]      rsp_magnetization_sum,
   output logic signed [ising_pkg::ENERGY_W-1:0]   rsp_energy_sum,
   input  logic                                    csr_wr_en,
   input  logic [ising_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ising_pkg::THRESH_W-1:0]          csr_wr_data
);

   // lattice geometry
   localparam int SITES   = SIDE * SIDE;
   localparam int ADDR_W  = $clog2(SITES);
   localparam int COL_W   = $clog2(SIDE);
   localparam int ROW_W   = $clog2(SIDE + 1);
   localparam int SITE_W  = ising_pkg::SITE_W;
   localparam int CMP_W   = (ADDR_W + 1 > SITE_W) ? ADDR_W + 1 : SITE_W;

   // column extraction: q = (site * RECIP) >> SITE_W is low by at most one
   localparam int RECIP   = (1 << SITE_W) / SIDE;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = SITE_W + RECIP_W;
   localparam int QS_W    = RECIP_W + COL_W + 1;

   // measure counters
   localparam int ONES_W  = $clog2(SITES + 1);
   localparam int UNEQ_W  = $clog2(2 * SITES + 1);
   localparam int ACC_W   = (UNEQ_W + 2 > ising_pkg::ENERGY_W + 1) ?
                            UNEQ_W + 2 : ising_pkg::ENERGY_W + 1;

   localparam logic signed [ACC_W-1:0] MAG_BIAS    = ACC_W'(SITES);
   localparam logic signed [ACC_W-1:0] ENERGY_BIAS = ACC_W'(2 * SITES);
   localparam logic signed [ACC_W-1:0] MAG_LO      = ACC_W'(ising_pkg::MAG_MIN);
   localparam logic signed [ACC_W-1:0] MAG_HI      = ACC_W'(ising_pkg::MAG_MAX);
   localparam logic signed [ACC_W-1:0] ENERGY_LO   = ACC_W'(ising_pkg::ENERGY_MIN);
   localparam logic signed [ACC_W-1:0] ENERGY_HI   = ACC_W'(ising_pkg::ENERGY_MAX);

   // neighbour address offsets, subtraction as a two's complement addend
   localparam logic [ADDR_W-1:0] ADD_NONE  = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] ADD_ONE   = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] SUB_ONE   = ADDR_W'((1 << ADDR_W) - 1);
   localparam logic [ADDR_W-1:0] ADD_HWRAP = ADDR_W'(SIDE - 1);
   localparam logic [ADDR_W-1:0] SUB_HWRAP = ADDR_W'((1 << ADDR_W) - (SIDE - 1));
   localparam logic [ADDR_W-1:0] ADD_SIDE  = ADDR_W'(SIDE);
   localparam logic [ADDR_W-1:0] SUB_SIDE  = ADDR_W'((1 << ADDR_W) - SIDE);
   localparam logic [ADDR_W-1:0] ADD_VWRAP = ADDR_W'(SITES - SIDE);
   localparam logic [ADDR_W-1:0] SUB_VWRAP = ADDR_W'((1 << ADDR_W) - (SITES - SIDE));

   // read steps of a flip attempt
   localparam logic [2:0] STEP_CENTER = 3'd0;
   localparam logic [2:0] STEP_RIGHT  = 3'd1;
   localparam logic [2:0] STEP_LEFT   = 3'd2;
   localparam logic [2:0] STEP_DOWN   = 3'd3;
   localparam logic [2:0] STEP_UP     = 3'd4;
   localparam logic [2:0] STEP_LAST   = 3'd5;

   // neighbours agreeing with the site: 3 means delta 4, 4 means delta 8
   localparam logic [2:0] NEIGHBOURS  = 3'd4;
   localparam logic [2:0] AGREE_FOUR  = 3'd3;
   localparam logic [2:0] AGREE_EIGHT = 3'd4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_REM,
      ST_COL,
      ST_READ,
      ST_DECIDE,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // control state
   state_type                      state_ff, state_in;
   logic [ADDR_W-1:0]              addr_cnt_ff, addr_cnt_in;
   logic                           dv_ff, dv_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ising_pkg::THRESH_W-1:0] thresh_four_ff, thresh_four_in;
   logic [ising_pkg::THRESH_W-1:0] thresh_eight_ff, thresh_eight_in;

   // flip attempt datapath
   logic [SITE_W-1:0]              site_ff, site_in;
   logic [ising_pkg::RAND_W-1:0]   rand_ff, rand_in;
   logic [PROD_W-1:0]              prod_ff, prod_in;
   logic [SITE_W-1:0]              rem_ff, rem_in;
   logic                           col_first_ff, col_first_in;
   logic                           col_last_ff, col_last_in;
   logic                           row_first_ff, row_first_in;
   logic                           row_last_ff, row_last_in;
   logic [2:0]                     step_ff, step_in;
   logic                           center_ff, center_in;
   logic [2:0]                     plus_ff, plus_in;

   // measure datapath
   logic [COL_W-1:0]               col_ff, col_in;
   logic [ROW_W-1:0]               row_ff, row_in;
   logic [COL_W-1:0]               col_d_ff, col_d_in;
   logic [ROW_W-1:0]               row_d_ff, row_d_in;
   logic                           prev_ff, prev_in;
   logic                           first_ff, first_in;
   logic [SIDE-1:0]                line_ff, line_in;
   logic [ONES_W-1:0]              ones_ff, ones_in;
   logic [UNEQ_W-1:0]              uneq_ff, uneq_in;

   // result registers
   logic                                  rsp_flipped_ff, rsp_flipped_in;
   logic                                  rsp_spin_after_ff, rsp_spin_after_in;
   logic signed [ising_pkg::MAG_W-1:0]    rsp_mag_ff, rsp_mag_in;
   logic signed [ising_pkg::ENERGY_W-1:0] rsp_energy_ff, rsp_energy_in;

   // combinational helpers
   logic [ADDR_W-1:0]        site_addr;
   logic [ADDR_W-1:0]        addend;
   logic [ADDR_W-1:0]        nb_addr;
   logic [QS_W-1:0]          q_times_side;
   logic [SITE_W-1:0]        col_value;
   logic                     site_in_lattice;
   logic [2:0]               agree;
   logic                     hit_four;
   logic                     hit_eight;
   logic                     flip;
   logic                     real_row;
   logic                     h_bond;
   logic                     w_bond;
   logic                     v_bond;
   logic signed [ACC_W-1:0]  mag_wide;
   logic signed [ACC_W-1:0]  energy_wide;
   logic signed [ACC_W-1:0]  mag_sat;
   logic signed [ACC_W-1:0]  energy_sat;

   // spin ram
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic              ram_rd_data;

   ising_ram #(
      .WIDTH (1),
      .DEPTH (SITES)
   ) u_spin_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign site_addr       = ADDR_W'(site_ff);
   assign site_in_lattice = CMP_W'(req_site) < CMP_W'(SITES);

   // shared neighbour adder, offset picked by read step and wrap flags
   always_comb begin
      case (step_ff)
         STEP_RIGHT: addend = col_last_ff  ? SUB_HWRAP : ADD_ONE;
         STEP_LEFT:  addend = col_first_ff ? ADD_HWRAP : SUB_ONE;
         STEP_DOWN:  addend = row_last_ff  ? SUB_VWRAP : ADD_SIDE;
         STEP_UP:    addend = row_first_ff ? ADD_VWRAP : SUB_SIDE;
         default:    addend = ADD_NONE;
      endcase
      nb_addr = site_addr + addend;
   end

   // column correction after the reciprocal estimate
   assign q_times_side = QS_W'(prod_ff[PROD_W-1 -: RECIP_W]) * QS_W'(SIDE);
   assign col_value    = (rem_ff >= SITE_W'(SIDE)) ? rem_ff - SITE_W'(SIDE) : rem_ff;

   // acceptance decision
   assign agree     = center_ff ? plus_ff : NEIGHBOURS - plus_ff;
   assign hit_four  = ising_pkg::THRESH_W'(rand_ff) < thresh_four_ff;
   assign hit_eight = ising_pkg::THRESH_W'(rand_ff) < thresh_eight_ff;
   assign flip      = (agree < AGREE_FOUR) ||
                      ((agree == AGREE_FOUR) && hit_four) ||
                      ((agree == AGREE_EIGHT) && hit_eight);

   // bonds seen by the measure stream; the extra row only closes vertical wraps
   assign real_row = row_d_ff != ROW_W'(SIDE);
   assign h_bond   = real_row && (col_d_ff != COL_W'(0)) && (ram_rd_data ^ prev_ff);
   assign w_bond   = real_row && (col_d_ff == COL_W'(SIDE - 1)) && (ram_rd_data ^ first_ff);
   assign v_bond   = (row_d_ff != ROW_W'(0)) && (ram_rd_data ^ line_ff[SIDE-1]);

   // magnetization = 2*ones - N, energy = 2*unequal - 2N, then saturate
   always_comb begin
      mag_wide    = signed'(ACC_W'({ones_ff, 1'b0})) - MAG_BIAS;
      energy_wide = signed'(ACC_W'({uneq_ff, 1'b0})) - ENERGY_BIAS;
      if (mag_wide < MAG_LO) begin
         mag_sat = MAG_LO;
      end else if (mag_wide > MAG_HI) begin
         mag_sat = MAG_HI;
      end else begin
         mag_sat = mag_wide;
      end
      if (energy_wide < ENERGY_LO) begin
         energy_sat = ENERGY_LO;
      end else if (energy_wide > ENERGY_HI) begin
         energy_sat = ENERGY_HI;
      end else begin
         energy_sat = energy_wide;
      end
   end

   // sequencer
   always_comb begin
      state_in          = state_ff;
      addr_cnt_in       = addr_cnt_ff;
      dv_in             = 1'b0;
      rsp_valid_in      = 1'b0;
      thresh_four_in    = thresh_four_ff;
      thresh_eight_in   = thresh_eight_ff;
      site_in           = site_ff;
      rand_in           = rand_ff;
      prod_in           = prod_ff;
      rem_in            = rem_ff;
      col_first_in      = col_first_ff;
      col_last_in       = col_last_ff;
      row_first_in      = row_first_ff;
      row_last_in       = row_last_ff;
      step_in           = step_ff;
      center_in         = center_ff;
      plus_in           = plus_ff;
      col_in            = col_ff;
      row_in            = row_ff;
      col_d_in          = col_d_ff;
      row_d_in          = row_d_ff;
      prev_in           = prev_ff;
      first_in          = first_ff;
      line_in           = line_ff;
      ones_in           = ones_ff;
      uneq_in           = uneq_ff;
      rsp_flipped_in    = rsp_flipped_ff;
      rsp_spin_after_in = rsp_spin_after_ff;
      rsp_mag_in        = rsp_mag_ff;
      rsp_energy_in     = rsp_energy_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = site_addr;
      ram_wr_data       = 1'b1;
      ram_rd_addr       = nb_addr;

      // threshold writes
      if (csr_wr_en) begin
         if (csr_index == ising_pkg::CSR_ACCEPT_FOUR) begin
            thresh_four_in = csr_wr_data;
         end
         if (csr_index == ising_pkg::CSR_ACCEPT_EIGHT) begin
            thresh_eight_in = csr_wr_data;
         end
      end

      // measure data stage, one ram word behind the walk
      if (dv_ff) begin
         ones_in  = ones_ff + ONES_W'(real_row && ram_rd_data);
         uneq_in  = uneq_ff + UNEQ_W'(h_bond) + UNEQ_W'(w_bond) + UNEQ_W'(v_bond);
         prev_in  = ram_rd_data;
         first_in = (col_d_ff == COL_W'(0)) ? ram_rd_data : first_ff;
         line_in  = {line_ff[SIDE-2:0], ram_rd_data};
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_cnt_ff;
            ram_wr_data = 1'b1;
            if (addr_cnt_ff == ADDR_W'(SITES - 1)) begin
               addr_cnt_in = ADDR_W'(0);
               state_in    = ST_IDLE;
            end else begin
               addr_cnt_in = addr_cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               site_in = req_site;
               rand_in = req_rand_value;
               if (req_kind == ising_pkg::KIND_MEASURE) begin
                  ones_in     = ONES_W'(0);
                  uneq_in     = UNEQ_W'(0);
                  col_in      = COL_W'(0);
                  row_in      = ROW_W'(0);
                  addr_cnt_in = ADDR_W'(0);
                  state_in    = ST_WALK;
               end else if (site_in_lattice) begin
                  state_in = ST_MUL;
               end else begin
                  // site beyond the lattice: answer at once, lattice untouched
                  rsp_valid_in      = 1'b1;
                  rsp_flipped_in    = 1'b0;
                  rsp_spin_after_in = 1'b0;
                  rsp_mag_in        = '0;
                  rsp_energy_in     = '0;
               end
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(site_ff) * PROD_W'(RECIP);
            state_in = ST_REM;
         end
         ST_REM: begin
            rem_in   = site_ff - q_times_side[SITE_W-1:0];
            state_in = ST_COL;
         end
         ST_COL: begin
            col_first_in = col_value == SITE_W'(0);
            col_last_in  = col_value == SITE_W'(SIDE - 1);
            row_first_in = site_addr < ADDR_W'(SIDE);
            row_last_in  = site_addr >= ADDR_W'(SITES - SIDE);
            step_in      = STEP_CENTER;
            plus_in      = 3'd0;
            state_in     = ST_READ;
         end
         ST_READ: begin
            ram_rd_addr = nb_addr;
            if (step_ff == STEP_RIGHT) begin
               center_in = ram_rd_data;
            end else if (step_ff != STEP_CENTER) begin
               plus_in = plus_ff + 3'(ram_rd_data);
            end
            if (step_ff == STEP_LAST) begin
               state_in = ST_DECIDE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_DECIDE: begin
            ram_wr_en         = flip;
            ram_wr_addr       = site_addr;
            ram_wr_data       = ~center_ff;
            rsp_valid_in      = 1'b1;
            rsp_flipped_in    = flip;
            rsp_spin_after_in = center_ff ^ flip;
            rsp_mag_in        = '0;
            rsp_energy_in     = '0;
            state_in          = ST_IDLE;
         end
         ST_WALK: begin
            ram_rd_addr = addr_cnt_ff;
            dv_in       = 1'b1;
            col_d_in    = col_ff;
            row_d_in    = row_ff;
            // row 0 is read again after the last row
            if (addr_cnt_ff == ADDR_W'(SITES - 1)) begin
               addr_cnt_in = ADDR_W'(0);
            end else begin
               addr_cnt_in = addr_cnt_ff + ADDR_W'(1);
            end
            if (col_ff == COL_W'(SIDE - 1)) begin
               col_in = COL_W'(0);
               row_in = row_ff + ROW_W'(1);
               if (row_ff == ROW_W'(SIDE)) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in      = 1'b1;
            rsp_flipped_in    = 1'b0;
            rsp_spin_after_in = 1'b0;
            rsp_mag_in        = mag_sat[ising_pkg::MAG_W-1:0];
            rsp_energy_in     = energy_sat[ising_pkg::ENERGY_W-1:0];
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         addr_cnt_ff     <= ADDR_W'(0);
         dv_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         thresh_four_ff  <= ising_pkg::ACCEPT_FOUR_RESET;
         thresh_eight_ff <= ising_pkg::ACCEPT_EIGHT_RESET;
      end else begin
         state_ff        <= state_in;
         addr_cnt_ff     <= addr_cnt_in;
         dv_ff           <= dv_in;
         rsp_valid_ff    <= rsp_valid_in;
         thresh_four_ff  <= thresh_four_in;
         thresh_eight_ff <= thresh_eight_in;
      end
      site_ff           <= site_in;
      rand_ff           <= rand_in;
      prod_ff           <= prod_in;
      rem_ff            <= rem_in;
      col_first_ff      <= col_first_in;
      col_last_ff       <= col_last_in;
      row_first_ff      <= row_first_in;
      row_last_ff       <= row_last_in;
      step_ff           <= step_in;
      center_ff         <= center_in;
      plus_ff           <= plus_in;
      col_ff            <= col_in;
      row_ff            <= row_in;
      col_d_ff          <= col_d_in;
      row_d_ff          <= row_d_in;
      prev_ff           <= prev_in;
      first_ff          <= first_in;
      line_ff           <= line_in;
      ones_ff           <= ones_in;
      uneq_ff           <= uneq_in;
      rsp_flipped_ff    <= rsp_flipped_in;
      rsp_spin_after_ff <= rsp_spin_after_in;
      rsp_mag_ff        <= rsp_mag_in;
      rsp_energy_ff     <= rsp_energy_in;
   end

   assign busy                  = state_ff != ST_IDLE;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_flipped           = rsp_flipped_ff;
   assign rsp_spin_after        = rsp_spin_after_ff;
   assign rsp_magnetization_sum = rsp_mag_ff;
   assign rsp_energy_sum        = rsp_energy_ff;

endmodule

FILE: rtl/ising_ram.sv
// generic single-write, single-read ram with registered read data
module ising_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ising_checker.sv
// port-level checks for the ising lattice engine, bound to the top level
module ising_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_valid,
   input logic                                  rsp_flipped,
   input logic                                  rsp_spin_after,
   input logic signed [ising_pkg::MAG_W-1:0]    rsp_magnetization_sum,
   input logic signed [ising_pkg::ENERGY_W-1:0] rsp_energy_sum
);

   // an accepted transaction either starts work or is answered at once
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted transaction neither started nor answered");

   // results only come out once the block has gone idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // every result follows work in progress or an acceptance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result strobe without a transaction");

   // busy only rises on an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without start");

   // measure results carry no flip outcome
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_magnetization_sum != 0 || rsp_energy_sum != 0)
         |-> !rsp_flipped && !rsp_spin_after)
      else $error("measure result with flip fields set");

endmodule

bind ising_metropolis_lattice ising_checker u_ising_checker (.*);
